// File: design/wsd_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Shared types, codes and helper functions for the frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    // Parse phases of the frame header and payload.
    typedef enum logic [2:0] {
        PH_HDR1    = 3'd0,
        PH_HDR2    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    // Sticky error codes.
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_RSV       = 3'd1,
        ERR_OPCODE    = 3'd2,
        ERR_UNMASKED  = 3'd3,
        ERR_TOO_LONG  = 3'd4,
        ERR_FRAG_CTRL = 3'd5
    } t_err;

    // Action reported when a frame completes.
    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_DELIVER  = 3'd1,
        ACT_CLOSE    = 3'd2,
        ACT_CTRL     = 3'd3,
        ACT_FRAGMENT = 3'd4
    } t_action;

    // Frame opcodes.
    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // Header field masks and length codes.
    localparam logic [7:0] HI_MASK   = 8'hF0;
    localparam logic [7:0] HI_FIN    = 8'h80;
    localparam logic [7:0] HI_NONE   = 8'h00;
    localparam logic [7:0] OP_MASK   = 8'h0F;
    localparam logic [7:0] LEN7_MASK = 8'h7F;
    localparam logic [6:0] LEN7_MAX  = 7'd125;
    localparam logic [6:0] LEN7_EXT16 = 7'd126;

    // Extended length byte counts, minus one.
    localparam logic [2:0] EXT16_LEFT = 3'd1;
    localparam logic [2:0] EXT64_LEFT = 3'd7;

    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

    // One result word.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        data_valid;
        logic        data_last;
        logic        frame_done;
        logic        frame_fin;
        logic [3:0]  frame_opcode;
        logic [63:0] frame_length;
        t_action     frame_action;
        logic        error_flag;
        t_err        error_kind;
    } t_result;

    function automatic logic opcode_known(input logic [3:0] op);
        return op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG};
    endfunction

    function automatic t_action frame_action_code(input logic fin, input logic [3:0] op);
        t_action act;
        if (!fin || op == OP_CONT) begin
            act = ACT_FRAGMENT;
        end else if (op == OP_TEXT || op == OP_BINARY) begin
            act = ACT_DELIVER;
        end else if (op == OP_CLOSE) begin
            act = ACT_CLOSE;
        end else begin
            act = ACT_CTRL;
        end
        return act;
    endfunction

endpackage

// File: design/wsd_parser.sv
// ----------------------------------------------------------------------------
// WebSocket deframer parser
// Holds the frame state, updates it for each accepted byte and forms the
// result word for that byte in the same cycle.
// ----------------------------------------------------------------------------
module wsd_parser import wsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_in_byte,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    output t_result     o_res
);

    t_phase      r_phase,        n_phase;
    logic        r_fin,          n_fin;
    logic [3:0]  r_opcode,       n_opcode;
    logic [63:0] r_length,       n_length;
    logic [2:0]  r_len_left,     n_len_left;
    logic [31:0] r_mask_key,     n_mask_key;
    logic [1:0]  r_mask_idx,     n_mask_idx;
    logic [63:0] r_payload_left, n_payload_left;
    t_err        r_error,        n_error;
    logic [31:0] r_max_payload;

    logic [7:0]  w_hi;
    logic [3:0]  w_op;
    logic [6:0]  w_len7;
    logic [63:0] w_ext_length;
    logic        w_active;

    assign w_hi         = i_in_byte & HI_MASK;
    assign w_op         = 4'(i_in_byte & OP_MASK);
    assign w_len7       = 7'(i_in_byte & LEN7_MASK);
    assign w_ext_length = {r_length[55:0], i_in_byte};
    assign w_active     = i_accept && (r_error == ERR_NONE);

    // Next state for one accepted byte; the state freezes once an error is set.
    always_comb begin
        n_phase        = r_phase;
        n_fin          = r_fin;
        n_opcode       = r_opcode;
        n_length       = r_length;
        n_len_left     = r_len_left;
        n_mask_key     = r_mask_key;
        n_mask_idx     = r_mask_idx;
        n_payload_left = r_payload_left;
        n_error        = r_error;
        if (w_active) begin
            case (r_phase)
                PH_HDR1: begin
                    if (w_hi != HI_FIN && w_hi != HI_NONE) begin
                        n_error = ERR_RSV;
                    end else if (!opcode_known(w_op)) begin
                        n_error = ERR_OPCODE;
                    end else begin
                        n_fin    = (w_hi == HI_FIN);
                        n_opcode = w_op;
                        if (w_hi != HI_FIN && w_op[3]) begin
                            n_error = ERR_FRAG_CTRL;
                        end else begin
                            n_phase = PH_HDR2;
                        end
                    end
                end
                PH_HDR2: begin
                    if (!i_in_byte[7]) begin
                        n_error = ERR_UNMASKED;
                    end else if (w_len7 <= LEN7_MAX) begin
                        n_length = 64'(w_len7);
                        if (r_max_payload < 32'(w_len7)) begin
                            n_error = ERR_TOO_LONG;
                        end else begin
                            n_mask_idx = 2'd0;
                            n_mask_key = 32'd0;
                            n_phase    = PH_MASK;
                        end
                    end else begin
                        n_length   = 64'd0;
                        n_len_left = (w_len7 == LEN7_EXT16) ? EXT16_LEFT : EXT64_LEFT;
                        n_phase    = PH_EXTLEN;
                    end
                end
                PH_EXTLEN: begin
                    n_length = w_ext_length;
                    if (r_len_left == 3'd0) begin
                        if (w_ext_length[63:32] != 32'd0 ||
                            w_ext_length[31:0] > r_max_payload) begin
                            n_error = ERR_TOO_LONG;
                        end else begin
                            n_mask_idx = 2'd0;
                            n_mask_key = 32'd0;
                            n_phase    = PH_MASK;
                        end
                    end else begin
                        n_len_left = r_len_left - 3'd1;
                    end
                end
                PH_MASK: begin
                    n_mask_key = {r_mask_key[23:0], i_in_byte};
                    n_mask_idx = r_mask_idx + 2'd1;
                    if (r_mask_idx == 2'd3) begin
                        if (r_length == 64'd0) begin
                            n_phase = PH_HDR1;
                        end else begin
                            n_payload_left = r_length;
                            n_phase        = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_mask_idx     = r_mask_idx + 2'd1;
                    n_payload_left = r_payload_left - 64'd1;
                    if (r_payload_left == 64'd1) begin
                        n_phase = PH_HDR1;
                    end
                end
                default: begin
                    n_phase = PH_HDR1;
                end
            endcase
        end
    end

    // Result word: payload unmasking, frame completion and the state after the byte.
    always_comb begin
        o_res              = '0;
        o_res.frame_action = ACT_NONE;
        o_res.error_kind   = n_error;
        o_res.error_flag   = (n_error != ERR_NONE);
        o_res.frame_fin    = n_fin;
        o_res.frame_opcode = n_opcode;
        o_res.frame_length = n_length;
        if (r_error == ERR_NONE) begin
            case (r_phase)
                PH_MASK: begin
                    if (r_mask_idx == 2'd3 && r_length == 64'd0) begin
                        o_res.frame_done   = 1'b1;
                        o_res.frame_action = frame_action_code(r_fin, r_opcode);
                    end
                end
                PH_PAYLOAD: begin
                    o_res.data_valid = 1'b1;
                    case (r_mask_idx)
                        2'd0:    o_res.data_byte = i_in_byte ^ r_mask_key[31:24];
                        2'd1:    o_res.data_byte = i_in_byte ^ r_mask_key[23:16];
                        2'd2:    o_res.data_byte = i_in_byte ^ r_mask_key[15:8];
                        default: o_res.data_byte = i_in_byte ^ r_mask_key[7:0];
                    endcase
                    if (r_payload_left == 64'd1) begin
                        o_res.data_last    = 1'b1;
                        o_res.frame_done   = 1'b1;
                        o_res.frame_action = frame_action_code(r_fin, r_opcode);
                    end
                end
                default: begin
                    o_res.frame_done = 1'b0;
                end
            endcase
        end
    end

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HDR1;
            r_fin          <= 1'b0;
            r_opcode       <= 4'd0;
            r_length       <= 64'd0;
            r_len_left     <= 3'd0;
            r_mask_key     <= 32'd0;
            r_mask_idx     <= 2'd0;
            r_payload_left <= 64'd0;
            r_error        <= ERR_NONE;
        end else begin
            r_phase        <= n_phase;
            r_fin          <= n_fin;
            r_opcode       <= n_opcode;
            r_length       <= n_length;
            r_len_left     <= n_len_left;
            r_mask_key     <= n_mask_key;
            r_mask_idx     <= n_mask_idx;
            r_payload_left <= n_payload_left;
            r_error        <= n_error;
        end
    end

    // Payload limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            r_max_payload <= i_cfg_data;
        end
    end

`ifndef NO_ASSERTIONS
    // An error, once raised, holds until reset.
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_error != ERR_NONE) |=> (r_error == $past(r_error)))
        else $error("sticky error changed");

    // Payload bytes are only produced in the payload phase with no error.
    a_data_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.data_valid |-> (r_phase == PH_PAYLOAD && r_error == ERR_NONE))
        else $error("data outside payload phase");

    // A frame that ends on a payload byte marks that byte as the last one.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.frame_done && o_res.data_valid) |-> o_res.data_last)
        else $error("frame end without last flag");

    // The payload phase always has bytes left to count.
    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (r_payload_left != 64'd0))
        else $error("payload phase with zero bytes left");
`endif

endmodule

// File: design/wsd_out_buf.sv
// ----------------------------------------------------------------------------
// WebSocket deframer output buffer
// Two-entry result queue that parts the input side from the output side.
// ----------------------------------------------------------------------------
module wsd_out_buf import wsd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_can_push,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    t_result    r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign o_can_push = (r_count != 2'd2);
    assign o_valid    = (r_count != 2'd0);
    assign w_pop      = o_valid && i_ready;
    assign o_res      = r_slot[r_rd_ptr];

    // Result storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_res;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // No word is written into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("push into full queue");

    // The fill count matches the pointer distance.
    a_count_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("count and pointers disagree");

    // The count never exceeds the depth.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("queue count out of range");
`endif

endmodule

// File: design/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses client-to-server WebSocket frames one byte at a time, unmasks the
// payload and reports frame completion and sticky protocol errors.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Word
//  --------+-----------+---------------------------+-----------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_in_byte
//  out     | output    | o_out_valid / i_out_ready | o_data_byte .. o_error_kind
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (max_payload)
//
//  Each accepted byte gives one result word, one byte per cycle sustained
//  while the output side keeps the queue from filling; the parse and the
//  unmasking lie between the frame state registers and a two-entry result
//  queue, and each result word is registered in that queue before the output.
//  Input ready drops only while the result queue holds two unread words.
//  Reset is synchronous and active low; it clears the frame state and errors,
//  and sets the payload limit to 65536. The configuration port is always ready.
// ----------------------------------------------------------------------------
module websocket_frame_deframer import wsd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_data_byte,
    output logic        o_data_valid,
    output logic        o_data_last,
    output logic        o_frame_done,
    output logic        o_frame_fin,
    output logic [3:0]  o_frame_opcode,
    output logic [63:0] o_frame_length,
    output logic [2:0]  o_frame_action,
    output logic        o_error_flag,
    output logic [2:0]  o_error_kind,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    logic    w_accept;
    t_result w_res;
    t_result w_out;

    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;

    // Frame parser and payload unmasking.
    wsd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_in_byte  (i_in_byte),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_res      (w_res)
    );

    // Result queue.
    wsd_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_accept),
        .i_res      (w_res),
        .o_can_push (o_in_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (w_out)
    );

    // Result word onto the output ports.
    assign o_data_byte    = w_out.data_byte;
    assign o_data_valid   = w_out.data_valid;
    assign o_data_last    = w_out.data_last;
    assign o_frame_done   = w_out.frame_done;
    assign o_frame_fin    = w_out.frame_fin;
    assign o_frame_opcode = w_out.frame_opcode;
    assign o_frame_length = w_out.frame_length;
    assign o_frame_action = w_out.frame_action;
    assign o_error_flag   = w_out.error_flag;
    assign o_error_kind   = w_out.error_kind;

endmodule
